/* hdl/swq_pkg.sv */
// Package for the semaphore wait queue table: request/status codes,
// state machine type and controller/datapath command and status structs.
// No dependencies.
package swq_pkg;

  localparam int MaxSemsDefault  = 32;
  localparam int MaxProcsDefault = 32;
  localparam int KeyWidth        = 32;
  localparam int ProcIdWidth     = 5;

  typedef enum logic [1:0] {
    REQ_BLOCK   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_PEEK    = 2'd2,
    REQ_UNBLOCK = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_DESC  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WALK,
    S_EXEC,
    S_OUT
  } swq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture request
    logic scan_start;  // clear descriptor scan
    logic scan_step;   // advance descriptor scan
    logic walk_start;  // begin queue walk from head
    logic walk_step;   // advance queue walk
    logic exec;        // commit state change and build result
  } swq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic need_walk;
    logic walk_done;
  } swq_stat_t;

endpackage

/* hdl/swq_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface swq_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/semaphore_wait_queue_table.sv */
// Top level of the semaphore wait queue table.
// Depends on swq_pkg, swq_if, swq_ctrl and swq_dp.
//
// Usage: requests arrive on req (sink of swq_if carrying req_type, sem_key,
// proc_id); one result per request leaves on rsp (source of swq_if carrying
// status, proc_out, proc_valid). Requests: block, release head, peek head,
// unblock named process. A descriptor is allocated for a new key on block
// and freed when its queue empties.
// Timing: one request at a time. Block, release and peek run a sequential key
// scan over the whole descriptor table before the result is valid. Unblock
// skips the scan and, when the process is not at the head, walks its queue
// from the head (up to MAX_PROCS entries).
// The next request is accepted the cycle after the result is taken.
// Reset (rst, synchronous) frees all descriptors and marks every process
// unblocked. A stalled result holds steady until rsp.ready is high.
module semaphore_wait_queue_table #(
  parameter int MAX_SEMS  = swq_pkg::MaxSemsDefault,
  parameter int MAX_PROCS = swq_pkg::MaxProcsDefault
) (
  input logic clk,
  input logic rst,
  swq_if.sink   req,
  swq_if.source rsp
);
  import swq_pkg::*;

  swq_cmd_t  cmd;
  swq_stat_t stat;

  swq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  swq_dp #(.MAX_SEMS(MAX_SEMS), .MAX_PROCS(MAX_PROCS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req.data.req_type),
    .sem_key    (req.data.sem_key),
    .proc_id    (req.data.proc_id),
    .status     (rsp.data.status),
    .proc_out   (rsp.data.proc_out),
    .proc_valid (rsp.data.proc_valid)
  );

  // never accept while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("request accepted while result pending");

  // a result rises only while no request can be accepted
  a_result_after_req: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> !req.ready) else $error("result without request");

  // proc_valid only with done status
  a_pv_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.proc_valid) |-> rsp.data.status == ST_DONE)
    else $error("proc_valid with failing status");
endmodule

/* hdl/swq_ctrl.sv */
// Controller for the semaphore wait queue table.
// Depends on swq_pkg.
module swq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output swq_pkg::swq_cmd_t  cmd,
  input  swq_pkg::swq_stat_t stat
);
  import swq_pkg::*;

  swq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SEARCH;
      S_SEARCH: if (stat.scan_done) state_next = stat.need_walk ? S_WALK : S_EXEC;
      S_WALK:   if (stat.walk_done) state_next = S_EXEC;
      S_EXEC:   state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.load       = in_valid;
        cmd.scan_start = in_valid;
      end
      S_SEARCH: begin
        cmd.scan_step  = !stat.scan_done;
        cmd.walk_start = stat.scan_done && stat.need_walk;
      end
      S_WALK:   cmd.walk_step = !stat.walk_done;
      S_EXEC:   cmd.exec = 1'b1;
      S_OUT:    out_valid = 1'b1;
      default:  ;
    endcase
  end
endmodule

/* hdl/swq_dp.sv */
// Datapath: descriptor and process tables, sequential key scan and
// queue walk, commit logic and result register. Depends on swq_pkg.
module swq_dp #(
  parameter int MAX_SEMS  = swq_pkg::MaxSemsDefault,
  parameter int MAX_PROCS = swq_pkg::MaxProcsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  swq_pkg::swq_cmd_t                cmd,
  output swq_pkg::swq_stat_t               stat,
  input  logic [1:0]                       req_type,
  input  logic [swq_pkg::KeyWidth-1:0]     sem_key,
  input  logic [swq_pkg::ProcIdWidth-1:0]  proc_id,
  output swq_pkg::status_t                 status,
  output logic [swq_pkg::ProcIdWidth-1:0]  proc_out,
  output logic                             proc_valid
);
  import swq_pkg::*;

  localparam int SW = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;
  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int SCW = $clog2(MAX_SEMS + 1);
  localparam int PCW = $clog2(MAX_PROCS + 1);

  // tables; in_use and blocked-valid are flops cleared at reset
  logic [MAX_SEMS-1:0]        desc_in_use;
  logic [KeyWidth-1:0]        desc_key  [MAX_SEMS];
  logic [PW-1:0]              desc_head [MAX_SEMS];
  logic [PW-1:0]              desc_tail [MAX_SEMS];
  logic [PW-1:0]              proc_next [MAX_PROCS];
  logic [MAX_PROCS-1:0]       proc_last;      // process is end of queue
  logic [MAX_PROCS-1:0]       proc_blk;       // process is blocked
  logic [SW-1:0]              proc_sem  [MAX_PROCS];

  // captured request
  req_type_t                  req;
  logic [KeyWidth-1:0]        key;
  logic [ProcIdWidth-1:0]     pid;
  logic                       pid_ok;
  logic [PW-1:0]              p;

  // scan state
  logic [SCW-1:0]             scan;
  logic                       found;
  logic [SW-1:0]              fd;
  logic                       have_free;
  logic [SW-1:0]              free_d;

  // walk state
  logic [PW-1:0]              cur;
  logic [PCW-1:0]             wcnt;
  logic                       wfound;

  logic [SW-1:0]              sidx;
  logic [SW-1:0]              ud;        // descriptor used by the operation
  logic                       u_ok;
  logic [PW-1:0]              tgt;       // process to unlink
  logic                       is_head;

  assign p    = PW'(pid);
  assign sidx = scan[SW-1:0];

  // descriptor of this request: key match, or blocked-on for unblock
  always_comb begin
    if (req == REQ_UNBLOCK) begin
      ud   = proc_sem[p];
      u_ok = pid_ok && proc_blk[p] && desc_in_use[proc_sem[p]];
    end else begin
      ud   = fd;
      u_ok = found;
    end
  end

  assign tgt     = (req == REQ_UNBLOCK) ? p : desc_head[ud];
  assign is_head = desc_head[ud] == tgt;

  assign stat.scan_done = (req == REQ_UNBLOCK) || (scan == SCW'(MAX_SEMS));
  assign stat.need_walk = (req == REQ_UNBLOCK) && u_ok && !is_head;
  assign stat.walk_done = wfound || proc_last[cur] || (wcnt == PCW'(MAX_PROCS));

  // request capture, scan and walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req    <= req_type_t'(req_type);
      key    <= sem_key;
      pid    <= proc_id;
      pid_ok <= 32'(proc_id) < MAX_PROCS;
    end
    if (cmd.scan_start) begin
      scan      <= '0;
      found     <= 1'b0;
      have_free <= 1'b0;
    end else if (cmd.scan_step) begin
      scan <= scan + SCW'(1);
      if (desc_in_use[sidx] && desc_key[sidx] == key && !found) begin
        found <= 1'b1;
        fd    <= sidx;
      end
      if (!desc_in_use[sidx] && !have_free) begin
        have_free <= 1'b1;
        free_d    <= sidx;
      end
    end
    if (cmd.walk_start) begin
      cur    <= desc_head[ud];
      wcnt   <= '0;
      wfound <= 1'b0;
    end else if (cmd.walk_step) begin
      wcnt <= wcnt + PCW'(1);
      if (proc_next[cur] == tgt) wfound <= 1'b1;
      else                       cur <= proc_next[cur];
    end
  end

  // commit
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_in_use <= '0;
      proc_blk    <= '0;
    end else if (cmd.exec) begin
      status     <= ST_NOT_FOUND;
      proc_out   <= '0;
      proc_valid <= 1'b0;
      unique case (req)
        REQ_BLOCK: begin
          if (pid_ok && !proc_blk[p]) begin
            if (found) begin
              proc_next[desc_tail[fd]] <= p;
              proc_last[desc_tail[fd]] <= 1'b0;
              desc_tail[fd] <= p;
              proc_sem[p]   <= fd;
              proc_next[p]  <= p;
              proc_last[p]  <= 1'b1;
              proc_blk[p]   <= 1'b1;
              status        <= ST_DONE;
            end else if (have_free) begin
              desc_in_use[free_d] <= 1'b1;
              desc_key[free_d]    <= key;
              desc_head[free_d]   <= p;
              desc_tail[free_d]   <= p;
              proc_sem[p]  <= free_d;
              proc_next[p] <= p;
              proc_last[p] <= 1'b1;
              proc_blk[p]  <= 1'b1;
              status       <= ST_DONE;
            end else begin
              status <= ST_NO_DESC;
            end
          end
        end
        REQ_RELEASE, REQ_PEEK, REQ_UNBLOCK: begin
          if (u_ok) begin
            status <= ST_DONE;
            if (req != REQ_UNBLOCK) begin
              proc_out   <= ProcIdWidth'(desc_head[ud]);
              proc_valid <= 1'b1;
            end
            if (req != REQ_PEEK) begin
              proc_blk[tgt] <= 1'b0;
              if (is_head) begin
                desc_head[ud] <= proc_next[tgt];
                if (proc_last[tgt]) desc_in_use[ud] <= 1'b0;
              end else if (wfound) begin
                proc_next[cur] <= proc_next[tgt];
                proc_last[cur] <= proc_last[tgt];
                if (desc_tail[ud] == tgt) desc_tail[ud] <= cur;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* tb/tb_swq_types.sv */
// Request and result payload types for the semaphore wait queue table bench.
// Depends on swq_pkg.
package tb_swq_types;
  import swq_pkg::*;

  typedef struct packed {
    req_type_t          req_type;
    logic [31:0]        sem_key;
    logic [4:0]         proc_id;
  } swq_req_t;

  typedef struct packed {
    status_t            status;
    logic [4:0]         proc_out;
    logic               proc_valid;
  } swq_rsp_t;
endpackage

/* tb/tb_semaphore_wait_queue_table.sv */
// Bench for semaphore_wait_queue_table: random and directed requests, a shadow
// queue table predicts each result, results are checked in order.
// Depends on swq_pkg, swq_if, tb_swq_types and the RTL.
module tb_semaphore_wait_queue_table;
  timeunit 1ns;
  timeprecision 1ps;
  import swq_pkg::*;
  import tb_swq_types::*;

  localparam int NSEM = 32;
  localparam int NPROC = 32;
  localparam int LIMIT = 2000000;

  // Shadow table plus queue of expected results
  class sem_table_board;
    bit          in_use [NSEM];
    bit [31:0]   key [NSEM];
    int          head [NSEM];
    int          tail [NSEM];
    int          nxt [NPROC];
    int          on_sem [NPROC];
    swq_rsp_t    pending [$];
    int          errors;
    int          checked;

    function void clear();
      foreach (in_use[i]) in_use[i] = 0;
      foreach (on_sem[i]) on_sem[i] = NSEM;
      errors = 0;
      checked = 0;
    endfunction

    function int lookup(bit [31:0] k);
      for (int d = 0; d < NSEM; d++) if (in_use[d] && key[d] == k) return d;
      return NSEM;
    endfunction

    function void take_out(int d, int p);
      int cur, nx;
      if (head[d] == p) begin
        head[d] = nxt[p];
        if (head[d] >= NPROC) in_use[d] = 0;
      end else begin
        cur = head[d];
        for (int i = 0; i < NPROC && cur < NPROC; i++) begin
          nx = nxt[cur];
          if (nx == p) begin
            nxt[cur] = nxt[p];
            if (tail[d] == p) tail[d] = cur;
            break;
          end
          cur = nx;
        end
      end
      on_sem[p] = NSEM;
    endfunction

    function void note_request(swq_req_t r);
      swq_rsp_t e;
      int d, p;
      e = '{ST_NOT_FOUND, 5'd0, 1'b0};
      p = r.proc_id;
      case (r.req_type)
        REQ_BLOCK: begin
          if (on_sem[p] == NSEM) begin
            d = lookup(r.sem_key);
            if (d == NSEM) begin
              for (d = 0; d < NSEM && in_use[d]; d++) ;
            end else nxt[tail[d]] = p;
            if (d >= NSEM) e.status = ST_NO_DESC;
            else begin
              if (!in_use[d]) begin
                in_use[d] = 1;
                key[d] = r.sem_key;
                head[d] = p;
              end
              tail[d] = p;
              nxt[p] = NPROC;
              on_sem[p] = d;
              e.status = ST_DONE;
            end
          end
        end
        REQ_RELEASE, REQ_PEEK: begin
          d = lookup(r.sem_key);
          if (d != NSEM) begin
            e = '{ST_DONE, 5'(head[d]), 1'b1};
            if (r.req_type == REQ_RELEASE) take_out(d, head[d]);
          end
        end
        default: begin
          d = on_sem[p];
          if (d < NSEM && in_use[d]) begin
            take_out(d, p);
            e.status = ST_DONE;
          end
        end
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(swq_rsp_t a);
      swq_rsp_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, a.status);
        errors++;
      end
      if (a.proc_out !== e.proc_out) begin
        $error("proc_out expected %0d actual %0d", e.proc_out, a.proc_out);
        errors++;
      end
      if (a.proc_valid !== e.proc_valid) begin
        $error("proc_valid expected %0d actual %0d", e.proc_valid, a.proc_valid);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  swq_if #(.payload_t(swq_req_t)) req_ch (.clk(clk));
  swq_if #(.payload_t(swq_rsp_t)) rsp_ch (.clk(clk));

  semaphore_wait_queue_table u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  sem_table_board board = new();
  bit quiet = 0;
  int cycles = 0;
  bit [31:0] keys [8];

  // Count cycles, check results at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.data);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side stalls in random bursts
  initial begin
    rsp_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      rsp_ch.ready <= 1;
    end
  end

  // Present one request; valid stays up until the next send or drain
  task automatic send(req_type_t t, bit [31:0] k, bit [4:0] p);
    swq_req_t r;
    r = '{t, k, p};
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req_ch.valid <= 1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_request(r);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    @(negedge clk);
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic bit [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return keys[$urandom_range(0, 7)];
  endfunction

  initial begin
    req_type_t t;
    req_ch.valid = 0;
    req_ch.data = '0;
    board.clear();
    keys = '{32'd0, 32'hFFFF_FFFF, 32'h1000, 32'hA5A5_5A5A, 32'd7, 32'h8000_0000,
             32'h1234_5678, 32'hDEAD_0001};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: unknown keys, key zero and all-ones, queue order, unblock cases
    send(REQ_PEEK, 32'd0, 5'd0);
    send(REQ_RELEASE, 32'hFFFF_FFFF, 5'd31);
    send(REQ_UNBLOCK, 32'd0, 5'd3);
    send(REQ_BLOCK, 32'd0, 5'd0);
    send(REQ_BLOCK, 32'd0, 5'd31);
    send(REQ_BLOCK, 32'd0, 5'd5);
    send(REQ_BLOCK, 32'hFFFF_FFFF, 5'd5);
    send(REQ_PEEK, 32'd0, 5'd0);
    send(REQ_UNBLOCK, 32'hFFFF_FFFF, 5'd31);
    send(REQ_UNBLOCK, 32'd0, 5'd5);
    send(REQ_UNBLOCK, 32'd0, 5'd0);
    send(REQ_RELEASE, 32'd0, 5'd0);
    send(REQ_RELEASE, 32'd0, 5'd0);
    // Fill the pool, then ask for one more descriptor with an already blocked process
    for (int i = 0; i < 32; i++) send(REQ_BLOCK, 32'h100 + i, 5'(i));
    send(REQ_BLOCK, 32'hFFFF_FFFF, 5'd0);
    send(REQ_UNBLOCK, 32'd0, 5'd31);
    send(REQ_BLOCK, 32'hFFFF_FFFF, 5'd31);
    send(REQ_PEEK, 32'hFFFF_FFFF, 5'd0);
    for (int i = 0; i < 32; i++) send(REQ_RELEASE, 32'h100 + i, 5'd0);
    send(REQ_RELEASE, 32'hFFFF_FFFF, 5'd0);
    drain();

    // Random: mostly a small key set so queues grow and shrink
    for (int n = 0; n < 1900; n++) begin
      if (n == 900) drain();
      if (n == 1700) quiet = 1;
      t = req_type_t'($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) t = REQ_BLOCK;
      send(t, pick_key(), 5'($urandom()));
    end
    drain();
    repeat (150) @(negedge clk);

    $display("ran %0d results through block, release, peek and unblock", board.checked);
    $display("including a full pool, key extremes and mid-queue unlinks");
    if (board.errors == 0 && board.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
